/* rtl/core/dq_pkg.sv */
// Shared types, codes and helpers for the double-ended queue.
// Used by dq_front, dq_cmd_fifo, dq_back and the top level.
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

  localparam int DEPTH    = 64;
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int SUM_W    = CNT_W + 1;
  localparam int DATA_W   = 32;
  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;

  // Depth of the command queue between front and back
  localparam int CQ_DEPTH = 2;
  localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

  localparam logic [OP_W-1:0] OP_CREATE    = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_HEAD = 3'd1;
  localparam logic [OP_W-1:0] OP_PUSH_TAIL = 3'd2;
  localparam logic [OP_W-1:0] OP_LIST_HEAD = 3'd3;
  localparam logic [OP_W-1:0] OP_LIST_TAIL = 3'd4;
  localparam logic [OP_W-1:0] OP_FILTER    = 3'd5;
  localparam logic [OP_W-1:0] OP_CLEAR     = 3'd6;

  localparam logic [STATUS_W-1:0] ST_DATA  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd3;

  // Decoded command; no flag set means an unused code (done, no change)
  typedef struct packed {
    logic                     create;
    logic                     clear;
    logic                     push;
    logic                     push_head;
    logic                     list;
    logic                     list_tail;
    logic                     filter;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  // Ring position of base + off; the sum stays below twice the depth
  function automatic logic [IDX_W-1:0] dq_wrap(input logic [IDX_W-1:0] base,
                                               input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) sum = sum - SUM_W'(DEPTH);
    return sum[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/dq_front.sv */
// Front end: accepts items and decodes the operation into a command.
// Depends on dq_pkg; feeds dq_cmd_fifo.
`timescale 1ns / 1ps
`default_nettype none

module dq_front (
  input  wire logic                          item_valid,
  output logic                               item_stall,
  input  wire logic [dq_pkg::OP_W-1:0]       op,
  input  wire logic signed [dq_pkg::DATA_W-1:0] value,
  input  wire logic                          fifo_full,
  output logic                               cmd_push,
  output dq_pkg::cmd_t                       cmd
);
  import dq_pkg::*;

  assign item_stall = fifo_full;
  assign cmd_push   = item_valid && !fifo_full;

  always_comb begin
    cmd           = '0;
    cmd.value     = value;
    case (op)
      OP_CREATE:    cmd.create = 1'b1;
      OP_PUSH_HEAD: begin
        cmd.push      = 1'b1;
        cmd.push_head = 1'b1;
      end
      OP_PUSH_TAIL: cmd.push = 1'b1;
      OP_LIST_HEAD: cmd.list = 1'b1;
      OP_LIST_TAIL: begin
        cmd.list      = 1'b1;
        cmd.list_tail = 1'b1;
      end
      OP_FILTER:    cmd.filter = 1'b1;
      OP_CLEAR:     cmd.clear = 1'b1;
      default:      cmd.value = value;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/dq_cmd_fifo.sv */
// Short command queue between the front end and the back end.
// Depends on dq_pkg for cmd_t and the queue depth.
`timescale 1ns / 1ps
`default_nettype none

module dq_cmd_fifo (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr_en,
  input  wire dq_pkg::cmd_t wr_cmd,
  output logic              full,
  input  wire logic         rd_en,
  output logic              rd_valid,
  output dq_pkg::cmd_t      rd_cmd
);
  import dq_pkg::*;

  cmd_t                slots [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr;
  logic [CQ_PTR_W-1:0] rd_ptr;
  logic [CQ_CNT_W-1:0] fill;

  assign full     = (fill == CQ_CNT_W'(CQ_DEPTH));
  assign rd_valid = (fill != '0);
  assign rd_cmd   = slots[rd_ptr];

  function automatic logic [CQ_PTR_W-1:0] bump(input logic [CQ_PTR_W-1:0] p);
    return (p == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en) slots[wr_ptr] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) wr_ptr <= bump(wr_ptr);
      if (rd_en) rd_ptr <= bump(rd_ptr);
      case ({wr_en, rd_en})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CQ_CNT_W'(CQ_DEPTH))
    else $error("command queue over-filled");
  a_no_write_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !wr_en)
    else $error("write into full command queue");
  a_no_read_empty: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> rd_valid)
    else $error("read from empty command queue");
`endif

endmodule

`default_nettype wire

/* rtl/core/dq_back.sv */
// Back end: holds the ring buffer and its pointers, carries out commands
// and drives the result register. Depends on dq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dq_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cmd_valid,
  input  wire dq_pkg::cmd_t                  cmd,
  output logic                               cmd_pop,
  output logic                               res_valid,
  input  wire logic                          res_stall,
  output logic signed [dq_pkg::DATA_W-1:0]   value_res,
  output logic [dq_pkg::STATUS_W-1:0]        status,
  output logic                               last
);
  import dq_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LREAD  = 3'd1;
  localparam logic [2:0] S_LEMIT  = 3'd2;
  localparam logic [2:0] S_FREAD  = 3'd3;
  localparam logic [2:0] S_FWRITE = 3'd4;
  localparam logic [2:0] S_EMPTY  = 3'd5;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [DATA_W-1:0] wr_data;

  logic [2:0]        state, state_next;
  logic [IDX_W-1:0]  head, head_next, head_dec;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  k, k_next;
  logic [CNT_W-1:0]  kept, kept_next, kept_inc;
  logic              tail, tail_next;
  logic [CNT_W-1:0]  count_last;
  logic              out_free;
  logic              load;
  logic [DATA_W-1:0] ld_value;
  logic [STATUS_W-1:0] ld_status;
  logic              ld_last;

  assign out_free   = !res_valid || !res_stall;
  assign head_dec   = (head == '0) ? IDX_W'(DEPTH - 1) : head - 1'b1;
  assign count_last = count - 1'b1;
  assign kept_inc   = rd_data[0] ? kept : kept + 1'b1;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    head_next  = head;
    count_next = count;
    k_next     = k;
    kept_next  = kept;
    tail_next  = tail;
    cmd_pop    = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = dq_wrap(head, count);
    wr_data    = cmd.value;
    rd_en      = 1'b0;
    rd_addr    = dq_wrap(head, k);
    load       = 1'b0;
    ld_value   = '0;
    ld_status  = ST_DONE;
    ld_last    = 1'b1;
    case (state)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          load    = 1'b1;
          if (cmd.create) begin
            head_next  = '0;
            count_next = CNT_W'(1);
            wr_en      = 1'b1;
            wr_addr    = '0;
          end else if (cmd.clear) begin
            head_next  = '0;
            count_next = '0;
          end else if (cmd.push) begin
            if (count == CNT_W'(DEPTH)) begin
              ld_status = ST_FULL;
            end else begin
              wr_en      = 1'b1;
              count_next = count + 1'b1;
              ld_status  = ST_DATA;
              ld_value   = cmd.value;
              if (cmd.push_head) begin
                head_next = head_dec;
                wr_addr   = head_dec;
              end
            end
          end else if (cmd.list || cmd.filter) begin
            if (count == '0) begin
              ld_status = ST_EMPTY;
            end else begin
              load       = 1'b0;
              k_next     = '0;
              kept_next  = '0;
              tail_next  = cmd.list_tail;
              state_next = cmd.filter ? S_FREAD : S_LREAD;
            end
          end
        end
      end
      S_LREAD: begin
        rd_en      = 1'b1;
        rd_addr    = dq_wrap(head, tail ? count_last - k : k);
        state_next = S_LEMIT;
      end
      S_LEMIT: begin
        if (out_free) begin
          load      = 1'b1;
          ld_status = ST_DATA;
          ld_value  = rd_data;
          ld_last   = (k == count_last);
          if (k == count_last) begin
            state_next = S_IDLE;
          end else begin
            k_next     = k + 1'b1;
            state_next = S_LREAD;
          end
        end
      end
      S_FREAD: begin
        rd_en      = 1'b1;
        state_next = S_FWRITE;
      end
      S_FWRITE: begin
        // keep even entries, packed towards the head in their old order
        wr_en     = !rd_data[0];
        wr_addr   = dq_wrap(head, kept);
        wr_data   = rd_data;
        kept_next = kept_inc;
        if (k == count_last) begin
          count_next = kept_inc;
          k_next     = '0;
          state_next = (kept_inc == '0) ? S_EMPTY : S_LREAD;
        end else begin
          k_next     = k + 1'b1;
          state_next = S_FREAD;
        end
      end
      S_EMPTY: begin
        if (out_free) begin
          load       = 1'b1;
          ld_status  = ST_EMPTY;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
      k     <= '0;
      kept  <= '0;
      tail  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      k     <= k_next;
      kept  <= kept_next;
      tail  <= tail_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value_res <= ld_value;
      status    <= ld_status;
      last      <= ld_last;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("element count beyond depth");
  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_LREAD || state == S_LEMIT || state == S_FREAD || state == S_FWRITE)
      |-> (k < count))
    else $error("walk index beyond element count");
  a_kept_le_k: assert property (@(posedge clk) disable iff (rst)
    (state == S_FREAD || state == S_FWRITE) |-> (kept <= k))
    else $error("filter write position overtook read position");
  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && status != ST_DATA) |-> (value_res == '0))
    else $error("non-data result carries a value");
`endif

endmodule

`default_nettype wire

/* rtl/core/deque_with_odd_value_filter.sv */
// Bounded double-ended queue of 64 signed 32-bit values in a ring buffer, with
// an in-place filter that drops odd values. Create, clear, both pushes and the
// unused code give one result each and sustain one item per cycle while the
// result side keeps up. A list reads and then emits each entry in turn, and a
// filter reads and rewrites each entry to compact the survivors, then lists
// them, or gives the empty result when none survive. Each entry takes a read
// state and then an emit or write state, as the buffer has a registered read.
// A two-entry command queue lets new items be taken while the back end walks.
`timescale 1ns / 1ps
`default_nettype none

module deque_with_odd_value_filter (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          item_valid,
  output logic                               item_stall,
  input  wire logic [dq_pkg::OP_W-1:0]       op,
  input  wire logic signed [dq_pkg::DATA_W-1:0] value,
  output logic                               res_valid,
  input  wire logic                          res_stall,
  output logic signed [dq_pkg::DATA_W-1:0]   value_res,
  output logic [dq_pkg::STATUS_W-1:0]        status,
  output logic                               last
);
  import dq_pkg::*;

  cmd_t front_cmd;
  cmd_t back_cmd;
  logic fifo_full;
  logic cmd_push;
  logic cmd_valid;
  logic cmd_pop;

  dq_front u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .op         (op),
    .value      (value),
    .fifo_full  (fifo_full),
    .cmd_push   (cmd_push),
    .cmd        (front_cmd)
  );

  dq_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cmd_push),
    .wr_cmd   (front_cmd),
    .full     (fifo_full),
    .rd_en    (cmd_pop),
    .rd_valid (cmd_valid),
    .rd_cmd   (back_cmd)
  );

  dq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (back_cmd),
    .cmd_pop   (cmd_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .value_res (value_res),
    .status    (status),
    .last      (last)
  );

endmodule

`default_nettype wire
